// ----- hw/rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the script line tokenizer
// Character codes, scan modes, event kinds and the per-byte event record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Event slots of one input byte, in emission order:
  // 0..2 the held slash as a token byte, its token end and line end,
  // 3..5 the current byte, its token end and line end,
  // 6 the line end from a newline or text end, 7 the text end itself.
  localparam int SLOTS  = 8;
  localparam int QDEPTH = 4;

  typedef enum logic [2:0] {
    MODE_LINE,
    MODE_GAP,
    MODE_PLAIN,
    MODE_QUOTE,
    MODE_COMMENT
  } mode_t;

  typedef enum logic [1:0] {
    EV_BYTE,
    EV_TOKEN,
    EV_LINE,
    EV_END
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  token_byte;
    logic [3:0]  arg_index;
    logic [6:0]  count_value;
  } event_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    event_t [SLOTS-1:0] ev;
  } record_t;

  function automatic event_t mk_event(kind_t kind, logic [7:0] byte_val,
                                      logic [3:0] idx, logic [6:0] cnt);
    event_t e;
    e.kind        = kind;
    e.token_byte  = byte_val;
    e.arg_index   = idx;
    e.count_value = cnt;
    return e;
  endfunction

endpackage

// ----- hw/rtl/script_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// script_line_tokenizer: streaming tokenizer for script text
// Splits script lines into tokens and reports token bytes, token ends, line
// ends and the end of the text as a stream of events.
// ----------------------------------------------------------------------------
// Usage:
// Text enters one byte per transaction on text_valid/text_stall/text_byte;
// a zero byte marks the end of a text. Events leave on event_valid/
// event_stall with kind, byte, argument index, count and a flag marking the
// final event raised by a byte. A byte that raises no event (blanks, comment
// text) only updates the scan state.
// The front end takes one byte per cycle unless the queue is full and writes
// its events as one record into a four-entry queue; the back end issues one
// event per cycle unless the receiver stalls. A byte's first event passes
// through the queue store and then the output register before it is shown.
// Sustained throughput is one transaction per cycle on whichever side carries
// more, and a byte that raises n events takes n output transactions.
// text_stall rises only when the queue is full. When the receiver stalls, the
// output event holds and the queue absorbs up to four more event-raising
// bytes. Reset clears the scan state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module script_line_tokenizer
  import slt_pkg::*;
#(
  parameter int MAX_ARGS    = 16,
  parameter int MAX_ARG_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  output logic       event_valid,
  input  logic       event_stall,
  output logic [1:0] event_kind,
  output logic [7:0] token_byte,
  output logic [3:0] arg_index,
  output logic [6:0] count_value,
  output logic       last_of_run
);

  logic    take;
  logic    push;
  logic    pop;
  logic    full;
  logic    nonempty;
  record_t rec;
  record_t head;

  assign text_stall = full;
  assign take       = text_valid && !full;

  slt_front #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_ARG_LEN (MAX_ARG_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (text_byte),
    .push      (push),
    .rec       (rec)
  );

  slt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_rec   (rec),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .full     (full)
  );

  slt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .nonempty    (nonempty),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .token_byte  (token_byte),
    .arg_index   (arg_index),
    .count_value (count_value),
    .last_of_run (last_of_run)
  );

endmodule

// ----- hw/rtl/slt_front.sv -----
// ----------------------------------------------------------------------------
// slt_front: byte classifier and scan state
// Holds the scan mode and counters, and turns each accepted byte into a record
// of up to eight ordered event slots for the back end.
// ----------------------------------------------------------------------------
module slt_front
  import slt_pkg::*;
#(
  parameter int MAX_ARGS    = 16,
  parameter int MAX_ARG_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte,
  output logic       push,
  output record_t    rec
);

  localparam int TW = $clog2(MAX_ARGS + 1);
  localparam int LW = $clog2(MAX_ARG_LEN);
  localparam logic [TW-1:0] ARG_LIMIT = TW'(MAX_ARGS);
  localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_ARG_LEN - 1);

  mode_t         mode, mode_next;
  logic          slash, slash_next;
  logic          swallow, swallow_next;
  logic [TW-1:0] tokens, tokens_next;
  logic [LW-1:0] length, length_next;

  logic live;
  logic do_add, do_fin, do_endl, do_end, quoted_cut;
  logic is_blank;

  assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB);

  always_comb begin
    mode_next    = mode;
    slash_next   = slash;
    swallow_next = swallow;
    tokens_next  = tokens;
    length_next  = length;
    rec          = '0;
    live         = 1'b1;
    do_add       = 1'b0;
    do_fin       = 1'b0;
    do_endl      = 1'b0;
    do_end       = 1'b0;
    quoted_cut   = 1'b0;

    // A quote straight after a quoted token cut at the length limit is dropped.
    if (swallow) begin
      swallow_next = 1'b0;
      if (text_byte == CH_QUOTE) live = 1'b0;
    end

    if (live && slash) begin
      slash_next = 1'b0;
      if (text_byte == CH_SLASH) begin
        mode_next = MODE_COMMENT;
        live      = 1'b0;
      end else begin
        // The held slash opens a plain token before this byte is handled.
        rec.mask[0] = 1'b1;
        rec.ev[0]   = mk_event(EV_BYTE, CH_SLASH, 4'(tokens_next), 7'd0);
        mode_next   = MODE_PLAIN;
        length_next = LW'(1);
        if (length_next == LEN_LIMIT) begin
          rec.mask[1] = 1'b1;
          rec.ev[1]   = mk_event(EV_TOKEN, 8'd0, 4'(tokens_next), 7'(length_next));
          tokens_next = tokens_next + TW'(1);
          length_next = '0;
          if (tokens_next >= ARG_LIMIT) begin
            rec.mask[2] = 1'b1;
            rec.ev[2]   = mk_event(EV_LINE, 8'd0, 4'd0, 7'(tokens_next));
            tokens_next = '0;
            mode_next   = MODE_LINE;
          end else begin
            mode_next = MODE_GAP;
          end
        end
      end
    end

    if (live) begin
      unique case (mode_next) inside
        MODE_LINE, MODE_GAP: begin
          if (is_blank) begin
          end else if ((text_byte == CH_CR) && (mode_next == MODE_LINE)) begin
          end else if (text_byte == CH_NL) begin
            do_endl = 1'b1;
          end else if (text_byte == CH_NUL) begin
            do_end = 1'b1;
          end else if (text_byte == CH_SLASH) begin
            slash_next = 1'b1;
          end else if (text_byte == CH_QUOTE) begin
            mode_next   = MODE_QUOTE;
            length_next = '0;
          end else begin
            mode_next   = MODE_PLAIN;
            length_next = '0;
            do_add      = 1'b1;
          end
        end
        MODE_PLAIN: begin
          if (is_blank) begin
            do_fin = 1'b1;
          end else if (text_byte == CH_NL) begin
            do_fin  = 1'b1;
            do_endl = 1'b1;
          end else if (text_byte == CH_NUL) begin
            do_fin = 1'b1;
            do_end = 1'b1;
          end else begin
            do_add = 1'b1;
          end
        end
        MODE_QUOTE: begin
          if (text_byte == CH_QUOTE) begin
            do_fin = 1'b1;
          end else if (text_byte == CH_NL) begin
            do_fin  = 1'b1;
            do_endl = 1'b1;
          end else if (text_byte == CH_NUL) begin
            do_fin = 1'b1;
            do_end = 1'b1;
          end else begin
            do_add = 1'b1;
          end
        end
        default: begin
          if (text_byte == CH_NL) do_endl = 1'b1;
          else if (text_byte == CH_NUL) do_end = 1'b1;
        end
      endcase

      if (do_add) begin
        rec.mask[3] = 1'b1;
        rec.ev[3]   = mk_event(EV_BYTE, text_byte, 4'(tokens_next), 7'd0);
        length_next = length_next + LW'(1);
        if (length_next == LEN_LIMIT) begin
          quoted_cut = (mode_next == MODE_QUOTE);
          do_fin     = 1'b1;
        end
      end

      if (do_fin) begin
        if (length_next != '0) begin
          rec.mask[4] = 1'b1;
          rec.ev[4]   = mk_event(EV_TOKEN, 8'd0, 4'(tokens_next), 7'(length_next));
          tokens_next = tokens_next + TW'(1);
        end
        length_next = '0;
        if (tokens_next >= ARG_LIMIT) begin
          rec.mask[5] = 1'b1;
          rec.ev[5]   = mk_event(EV_LINE, 8'd0, 4'd0, 7'(tokens_next));
          tokens_next = '0;
          mode_next   = MODE_LINE;
        end else begin
          mode_next = MODE_GAP;
        end
      end

      if (quoted_cut) swallow_next = 1'b1;

      if (do_endl || do_end) begin
        if (tokens_next != '0) begin
          rec.mask[6] = 1'b1;
          rec.ev[6]   = mk_event(EV_LINE, 8'd0, 4'd0, 7'(tokens_next));
        end
        tokens_next = '0;
        length_next = '0;
        mode_next   = MODE_LINE;
      end

      if (do_end) begin
        rec.mask[7]  = 1'b1;
        rec.ev[7]    = mk_event(EV_END, 8'd0, 4'd0, 7'd0);
        mode_next    = MODE_LINE;
        slash_next   = 1'b0;
        swallow_next = 1'b0;
      end
    end
  end

  assign push = take && (rec.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_LINE;
      slash   <= 1'b0;
      swallow <= 1'b0;
      tokens  <= '0;
      length  <= '0;
    end else if (take) begin
      mode    <= mode_next;
      slash   <= slash_next;
      swallow <= swallow_next;
      tokens  <= tokens_next;
      length  <= length_next;
    end
  end

endmodule

// ----- hw/rtl/slt_queue.sv -----
// ----------------------------------------------------------------------------
// slt_queue: record queue between front and back end
// A small first-in first-out store of event records, so that a byte which
// raises several events does not hold up the bytes behind it at once.
// ----------------------------------------------------------------------------
module slt_queue
  import slt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  record_t wr_rec,
  input  logic    pop,
  output record_t head,
  output logic    nonempty,
  output logic    full
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  record_t         store [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ----- hw/rtl/slt_back.sv -----
// ----------------------------------------------------------------------------
// slt_back: event serialiser and output register
// Walks the pending slots of the record at the head of the queue, lowest slot
// first, and presents one event per transaction on the output channel.
// ----------------------------------------------------------------------------
module slt_back
  import slt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  record_t     head,
  input  logic        nonempty,
  output logic        pop,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  token_byte,
  output logic [3:0]  arg_index,
  output logic [6:0]  count_value,
  output logic        last_of_run
);

  localparam int SW = $clog2(SLOTS);

  logic [SLOTS-1:0] taken;
  logic [SLOTS-1:0] pending;
  logic [SLOTS-1:0] pick_bit;
  logic [SLOTS-1:0] rest;
  logic [SW-1:0]    pick_idx;
  logic             found;
  logic             load;
  event_t           ev_out;
  logic             last_out;

  assign pending = head.mask & ~taken;

  always_comb begin
    pick_idx = '0;
    found    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && pending[i]) begin
        pick_idx = SW'(i);
        found    = 1'b1;
      end
    end
  end

  assign pick_bit = SLOTS'(1) << pick_idx;
  assign rest     = pending & ~pick_bit;
  assign load     = nonempty && (!event_valid || !event_stall);
  assign pop      = load && (rest == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      ev_out   <= head.ev[pick_idx];
      last_out <= (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      taken       <= '0;
    end else begin
      if (load) begin
        event_valid <= 1'b1;
        if (rest == '0) taken <= '0;
        else taken <= taken | pick_bit;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
  end

  assign event_kind  = ev_out.kind;
  assign token_byte  = ev_out.token_byte;
  assign arg_index   = ev_out.arg_index;
  assign count_value = ev_out.count_value;
  assign last_of_run = last_out;

endmodule

// ----- hw/rtl/slt_checker.sv -----
// ----------------------------------------------------------------------------
// slt_checker: port-level checks for the script line tokenizer
// Watches the output channel for stall behaviour, reset behaviour and the
// fixed fields of line and text-end events.
// ----------------------------------------------------------------------------
module slt_checker
  import slt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       text_valid,
  input logic       text_stall,
  input logic [7:0] text_byte,
  input logic       event_valid,
  input logic       event_stall,
  input logic [1:0] event_kind,
  input logic [7:0] token_byte,
  input logic [3:0] arg_index,
  input logic [6:0] count_value,
  input logic       last_of_run
);

  logic in_take;

  assign in_take = text_valid && !text_stall && (text_byte == CH_NUL);

  // A stalled event stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=>
      event_valid && $stable(event_kind) && $stable(token_byte) &&
      $stable(arg_index) && $stable(count_value) && $stable(last_of_run))
    else $error("stalled event changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !event_valid)
    else $error("event shown straight after reset");

  // Text end is always the final event of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_kind == EV_END) |-> last_of_run)
    else $error("text end not marked as last");

  a_fixed_fields: assert property (@(posedge clk) disable iff (rst || in_take)
    event_valid && ((event_kind == EV_LINE) || (event_kind == EV_END)) |->
      (token_byte == 8'd0) && (arg_index == 4'd0))
    else $error("line or text end event carries byte or index");

endmodule

bind script_line_tokenizer slt_checker u_slt_checker (.*);

// ----- tb/tb_script_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_script_line_tokenizer: self-checking bench for the script line tokenizer
// A short table of hand-picked characters is followed by randomly built
// script lines (plain, quoted and slash-led tokens, comments, over-long
// tokens, over-full lines) and some raw noise. Every event is checked in order
// against the table or a behavioural tokenizer model. The sender and receiver
// idle at several rates, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_script_line_tokenizer;
  import slt_pkg::*;

  localparam int TOKENS_PER_LINE = 16;
  localparam int TOKEN_LEN_LIMIT = 64;
  localparam int EVENTS_PER_CHAR = 6;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 150;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASE_CHARS     = 12;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tbyte;
    logic [3:0] idx;
    logic [6:0] cnt;
    logic       last;
  } tok_event_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_ONE
  } row_check_t;

  typedef struct packed {
    logic [7:0] ch;
    row_check_t chk;
    tok_event_t ev;
  } row_t;

  // Rows marked ROW_ONE expect exactly that single event; ROW_QUIET expects
  // none; ROW_PREDICT rows are left to the model.
  localparam row_t DIRECTED_ROWS [0:25] = '{
    '{CH_NUL,   ROW_ONE,     '{EV_END,   8'h00, 4'd0, 7'd0, 1'b1}},
    '{CH_SPACE, ROW_QUIET,   '0},
    '{CH_TAB,   ROW_QUIET,   '0},
    '{CH_CR,    ROW_QUIET,   '0},
    '{CH_NL,    ROW_QUIET,   '0},
    '{8'h41,    ROW_ONE,     '{EV_BYTE,  8'h41, 4'd0, 7'd0, 1'b1}},
    '{8'hFF,    ROW_ONE,     '{EV_BYTE,  8'hFF, 4'd0, 7'd0, 1'b1}},
    '{CH_SPACE, ROW_ONE,     '{EV_TOKEN, 8'h00, 4'd0, 7'd2, 1'b1}},
    '{CH_CR,    ROW_ONE,     '{EV_BYTE,  CH_CR, 4'd1, 7'd0, 1'b1}},
    '{CH_TAB,   ROW_ONE,     '{EV_TOKEN, 8'h00, 4'd1, 7'd1, 1'b1}},
    '{CH_QUOTE, ROW_QUIET,   '0},
    '{CH_QUOTE, ROW_QUIET,   '0},
    '{CH_QUOTE, ROW_QUIET,   '0},
    '{8'h71,    ROW_PREDICT, '0},
    '{CH_SPACE, ROW_PREDICT, '0},
    '{CH_QUOTE, ROW_PREDICT, '0},
    '{CH_SLASH, ROW_QUIET,   '0},
    '{CH_SLASH, ROW_QUIET,   '0},
    '{CH_QUOTE, ROW_QUIET,   '0},
    '{CH_NL,    ROW_PREDICT, '0},
    '{CH_SLASH, ROW_QUIET,   '0},
    '{8'h78,    ROW_PREDICT, '0},
    '{CH_NL,    ROW_PREDICT, '0},
    '{CH_SLASH, ROW_QUIET,   '0},
    '{CH_SLASH, ROW_QUIET,   '0},
    '{CH_NUL,   ROW_ONE,     '{EV_END,   8'h00, 4'd0, 7'd0, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte = 8'h00;
  logic       event_valid;
  logic       event_stall = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] token_byte;
  logic [3:0] arg_index;
  logic [6:0] count_value;
  logic       last_of_run;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold      = 1'b0;
  int hold_count     = 0;
  int cycle_count    = 0;
  int failures       = 0;
  int random_sent    = 0;

  // Tokenizer model state.
  mode_t scan_state  = MODE_LINE;
  bit    slash_held  = 1'b0;
  bit    quote_drop  = 1'b0;
  int    line_tokens = 0;
  int    token_len   = 0;

  tok_event_t char_events[$];
  tok_event_t expected_events[$];
  logic [7:0] line_bytes[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  script_line_tokenizer #(
    .MAX_ARGS    (TOKENS_PER_LINE),
    .MAX_ARG_LEN (TOKEN_LEN_LIMIT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .token_byte  (token_byte),
    .arg_index   (arg_index),
    .count_value (count_value),
    .last_of_run (last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Tokenizer model
  // ---------------------------------------------------------------------------
  function void add_event(kind_t k, logic [7:0] c, int idx, int cnt);
    tok_event_t e;
    e.kind  = k;
    e.tbyte = c;
    e.idx   = 4'(idx);
    e.cnt   = 7'(cnt);
    e.last  = 1'b0;
    if (char_events.size() < EVENTS_PER_CHAR) char_events.push_back(e);
  endfunction

  function void close_token();
    if (token_len > 0) begin
      add_event(EV_TOKEN, 8'h00, line_tokens, token_len);
      line_tokens++;
    end
    token_len = 0;
    if (line_tokens >= TOKENS_PER_LINE) begin
      add_event(EV_LINE, 8'h00, 0, line_tokens);
      line_tokens = 0;
      scan_state  = MODE_LINE;
    end else begin
      scan_state = MODE_GAP;
    end
  endfunction

  function void close_line();
    if (line_tokens > 0) add_event(EV_LINE, 8'h00, 0, line_tokens);
    line_tokens = 0;
    token_len   = 0;
    scan_state  = MODE_LINE;
  endfunction

  function void close_text();
    close_line();
    add_event(EV_END, 8'h00, 0, 0);
    scan_state  = MODE_LINE;
    slash_held  = 1'b0;
    quote_drop  = 1'b0;
    line_tokens = 0;
    token_len   = 0;
  endfunction

  function void append_char(logic [7:0] c);
    bit was_quoted;
    add_event(EV_BYTE, c, line_tokens, 0);
    token_len++;
    if (token_len >= TOKEN_LEN_LIMIT - 1) begin
      was_quoted = (scan_state == MODE_QUOTE);
      close_token();
      if (was_quoted) quote_drop = 1'b1;
    end
  endfunction

  function void open_plain(logic [7:0] c);
    scan_state = MODE_PLAIN;
    token_len  = 0;
    append_char(c);
  endfunction

  function void scan_char(logic [7:0] c);
    case (scan_state) inside
      MODE_LINE, MODE_GAP: begin
        if (c == CH_SPACE || c == CH_TAB) begin
        end else if (c == CH_CR && scan_state == MODE_LINE) begin
        end else if (c == CH_NL) begin
          close_line();
        end else if (c == CH_NUL) begin
          close_text();
        end else if (c == CH_SLASH) begin
          slash_held = 1'b1;
        end else if (c == CH_QUOTE) begin
          scan_state = MODE_QUOTE;
          token_len  = 0;
        end else begin
          open_plain(c);
        end
      end
      MODE_PLAIN, MODE_QUOTE: begin
        if (scan_state == MODE_PLAIN && (c == CH_SPACE || c == CH_TAB)) begin
          close_token();
        end else if (scan_state == MODE_QUOTE && c == CH_QUOTE) begin
          close_token();
        end else if (c == CH_NL) begin
          close_token();
          close_line();
        end else if (c == CH_NUL) begin
          close_token();
          close_text();
        end else begin
          append_char(c);
        end
      end
      default: begin
        if (c == CH_NL) close_line();
        else if (c == CH_NUL) close_text();
      end
    endcase
  endfunction

  // Works out every event raised by one text character, in order.
  function void predict_events(logic [7:0] c);
    bit dropped;
    dropped = 1'b0;
    char_events.delete();
    if (quote_drop) begin
      quote_drop = 1'b0;
      dropped    = (c == CH_QUOTE);
    end
    if (!dropped) begin
      if (slash_held) begin
        slash_held = 1'b0;
        if (c == CH_SLASH) begin
          scan_state = MODE_COMMENT;
        end else begin
          open_plain(CH_SLASH);
          scan_char(c);
        end
      end else begin
        scan_char(c);
      end
    end
    if (char_events.size() > 0) char_events[char_events.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] body_char(bit quoted);
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(33, 126));
    end while (c == CH_NL || (quoted && c == CH_QUOTE) ||
               (!quoted && (c == CH_SPACE || c == CH_TAB)));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] awkward_char();
    case ($urandom_range(0, 6))
      0:       return CH_NUL;
      1:       return CH_TAB;
      2:       return CH_NL;
      3:       return CH_CR;
      4:       return CH_SPACE;
      5:       return CH_QUOTE;
      default: return CH_SLASH;
    endcase
  endfunction

  // A well-formed line with random content: tokens of several styles, an
  // optional trailing comment, ended by a newline or now and then a text end.
  task automatic build_line(input int tok_lo, input int tok_hi, input int long_pct);
    int ntok;
    int len;
    int style;
    repeat ($urandom_range(0, 2))
      line_bytes.push_back(($urandom_range(0, 2) == 0) ? CH_CR : blank_char());
    ntok = $urandom_range(tok_lo, tok_hi);
    for (int i = 0; i < ntok; i++) begin
      len   = ($urandom_range(0, 99) < long_pct) ? $urandom_range(60, 66)
                                                 : $urandom_range(1, 6);
      style = $urandom_range(0, 9);
      if (i > 0) repeat ($urandom_range(1, 2)) line_bytes.push_back(blank_char());
      if (style <= 5) begin
        repeat (len) line_bytes.push_back(body_char(1'b0));
      end else if (style <= 7) begin
        line_bytes.push_back(CH_QUOTE);
        repeat (len) line_bytes.push_back(body_char(1'b1));
        if ($urandom_range(0, 9) != 0) line_bytes.push_back(CH_QUOTE);
      end else if (style == 8) begin
        line_bytes.push_back(CH_SLASH);
        repeat (len) line_bytes.push_back(body_char(1'b0));
      end else begin
        line_bytes.push_back(CH_QUOTE);
        line_bytes.push_back(CH_QUOTE);
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      line_bytes.push_back(blank_char());
      line_bytes.push_back(CH_SLASH);
      line_bytes.push_back(CH_SLASH);
      repeat ($urandom_range(0, 4)) line_bytes.push_back(body_char(1'b1));
    end
    if ($urandom_range(0, 3) == 0) line_bytes.push_back(CH_CR);
    line_bytes.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_NL);
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input row_check_t chk,
                           input tok_event_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= c;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    predict_events(c);
    case (chk)
      ROW_PREDICT: foreach (char_events[i]) expected_events.push_back(char_events[i]);
      ROW_ONE:     expected_events.push_back(typed);
      default:     ;
    endcase
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_char(line_bytes[i], ROW_PREDICT, '0);
    random_sent += line_bytes.size();
    line_bytes.delete();
  endtask

  task automatic run_phase(input int budget);
    int goal;
    int pick;
    goal = random_sent + budget;
    while (random_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        build_line(1, 5, 4);
      end else if (pick == 8) begin
        build_line(14, 18, 0);
      end else begin
        repeat ($urandom_range(1, 8))
          line_bytes.push_back(($urandom_range(0, 1) == 0) ? awkward_char()
                                                           : 8'($urandom_range(0, 255)));
      end
      send_line();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while long_hold is set.
  always @(posedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      event_stall <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      event_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Each accepted event is compared with the oldest expected one.
  always @(posedge clk) begin
    tok_event_t got;
    tok_event_t want;
    if (!rst && event_valid && !event_stall) begin
      got = {kind_t'(event_kind), token_byte, arg_index, count_value, last_of_run};
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected event: kind %0d byte %02h index %0d count %0d last %0b",
                   got.kind, got.tbyte, got.idx, got.cnt, got.last);
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: exp %0d %02h %0d %0d %0b, got %0d %02h %0d %0d %0b",
                     want.kind, want.tbyte, want.idx, want.cnt, want.last,
                     got.kind, got.tbyte, got.idx, got.cnt, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].chk, DIRECTED_ROWS[i].ev);

    // Back to back: a quoted token cut at the limit with its closing quote
    // straight after, then a line of one-character tokens past the limit.
    line_bytes.push_back(CH_QUOTE);
    repeat (TOKEN_LEN_LIMIT - 1) line_bytes.push_back(body_char(1'b1));
    line_bytes.push_back(CH_QUOTE);
    line_bytes.push_back(CH_NL);
    send_line();
    repeat (TOKENS_PER_LINE + 1) begin
      line_bytes.push_back(body_char(1'b0));
      line_bytes.push_back(CH_SPACE);
    end
    line_bytes.push_back(CH_NL);
    send_line();
    run_phase(PHASE_CHARS);

    send_idle_pct  = 63;
    recv_stall_pct = 0;
    run_phase(PHASE_CHARS);

    send_idle_pct  = 0;
    recv_stall_pct = 63;
    run_phase(PHASE_CHARS);

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    run_phase(PHASE_CHARS);

    // The sender keeps offering through the hold-off so the block backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold      = 1'b1;
    run_phase(PHASE_CHARS);
    long_hold      = 1'b0;

    text_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
